// ===== rtl/i2cbe_pkg.sv =====
// Package with shared types, codes and phase tables for the I2C master bit engine.
`timescale 1ns / 1ps
package i2cbe_pkg;

   localparam int BitsPerByte = 8;
   localparam int BitIdxW     = $clog2(BitsPerByte);
   localparam int HoldW       = 8;
   localparam logic [HoldW-1:0] HoldReset = 8'd5;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_START     = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_SEND_BYTE = 3'd3,
      CMD_RECV_BYTE = 3'd4,
      CMD_SEND_ACK  = 3'd5,
      CMD_RECV_ACK  = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      OP_SDA_HIGH,
      OP_SDA_LOW,
      OP_SDA_DATA,
      OP_SDA_ACK,
      OP_SCL_HIGH,
      OP_SCL_LOW,
      OP_SAMPLE_BIT,
      OP_SAMPLE_ACK
   } op_type;

   localparam logic [1:0] StepFirst = 2'd0;
   localparam logic [1:0] StepMid   = 2'd1;
   localparam logic [1:0] StepBit   = 2'd2;
   localparam logic [1:0] StepLead  = 2'd3;

   typedef struct packed {
      logic            scl_level;
      logic            sda_drive;
      logic            busy_res;
      logic            done_res;
      logic [7:0]      rx_byte;
      logic            ack_seen;
   } res_type;

   function automatic op_type op_of(input cmd_type cmd, input logic [1:0] step);
      op_type op;
      op = OP_SDA_HIGH;
      case (cmd)
         CMD_START: begin
            case (step)
               StepFirst: op = OP_SDA_HIGH;
               StepMid:   op = OP_SCL_HIGH;
               StepBit:   op = OP_SDA_LOW;
               default:   op = OP_SCL_LOW;
            endcase
         end
         CMD_STOP: begin
            case (step)
               StepFirst: op = OP_SDA_LOW;
               StepMid:   op = OP_SCL_HIGH;
               default:   op = OP_SDA_HIGH;
            endcase
         end
         CMD_SEND_BYTE: begin
            case (step)
               StepFirst: op = OP_SDA_DATA;
               StepMid:   op = OP_SCL_HIGH;
               default:   op = OP_SCL_LOW;
            endcase
         end
         CMD_RECV_BYTE: begin
            case (step)
               StepFirst: op = OP_SCL_HIGH;
               StepMid:   op = OP_SAMPLE_BIT;
               StepBit:   op = OP_SCL_LOW;
               default:   op = OP_SDA_HIGH;
            endcase
         end
         CMD_SEND_ACK: begin
            case (step)
               StepFirst: op = OP_SDA_ACK;
               StepMid:   op = OP_SCL_HIGH;
               default:   op = OP_SCL_LOW;
            endcase
         end
         default: begin
            case (step)
               StepFirst: op = OP_SDA_HIGH;
               StepMid:   op = OP_SCL_HIGH;
               StepBit:   op = OP_SAMPLE_ACK;
               default:   op = OP_SCL_LOW;
            endcase
         end
      endcase
      return op;
   endfunction

   function automatic logic is_last(input cmd_type cmd, input logic [1:0] step,
                                    input logic last_bit);
      logic last;
      case (cmd)
         CMD_START:     last = (step == StepLead);
         CMD_STOP:      last = (step == StepBit);
         CMD_SEND_BYTE: last = (step == StepBit) && last_bit;
         CMD_RECV_BYTE: last = (step == StepBit) && last_bit;
         CMD_SEND_ACK:  last = (step == StepBit);
         CMD_RECV_ACK:  last = (step == StepLead);
         default:       last = 1'b0;
      endcase
      return last;
   endfunction

endpackage

// ===== rtl/i2cbe_req_if.sv =====
// Channel interface carrying one engine tick request.
`timescale 1ns / 1ps
interface i2cbe_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] tx_byte;
   logic       ack_to_send;
   logic       sda_in;

   modport source (output valid, action, tx_byte, ack_to_send, sda_in, input ready);
   modport sink   (input valid, action, tx_byte, ack_to_send, sda_in, output ready);
endinterface

// ===== rtl/i2cbe_rsp_if.sv =====
// Channel interface carrying one engine tick response.
`timescale 1ns / 1ps
interface i2cbe_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_level;
   logic       sda_drive;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_seen;

   modport source (output valid, scl_level, sda_drive, busy_res, done_res, rx_byte, ack_seen,
                   input ready);
   modport sink   (input valid, scl_level, sda_drive, busy_res, done_res, rx_byte, ack_seen,
                   output ready);
endinterface

// ===== rtl/i2cbe_core.sv =====
// Command sequencer state and per-tick next-state logic of the I2C master bit engine.
`timescale 1ns / 1ps
module i2cbe_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_en,
   input  logic [i2cbe_pkg::HoldW-1:0] hold_ticks,
   input  logic [2:0]                 action,
   input  logic [7:0]                 tx_byte,
   input  logic                       ack_to_send,
   input  logic                       sda_in,
   output i2cbe_pkg::res_type         res
);

   i2cbe_pkg::cmd_type               cmd_ff, cmd_in, cmd_cur;
   logic [1:0]                       step_ff, step_in, step_cur;
   logic [i2cbe_pkg::BitIdxW-1:0]    bit_ff, bit_in, bit_cur;
   logic [i2cbe_pkg::HoldW-1:0]      hold_ff, hold_in, hold_cur;
   logic [7:0]                       shift_ff, shift_in, shift_cur;
   logic                             fin_ff, fin_in, fin_cur;
   logic                             scl_ff, scl_in;
   logic                             sda_ff, sda_in_nx;
   logic                             ack_ff, ack_in;
   logic [7:0]                       rx_ff, rx_in;

   logic                             launch;
   logic                             active;
   logic                             run;
   logic                             last_bit;
   logic                             finish;
   i2cbe_pkg::op_type                op;
   logic [i2cbe_pkg::BitIdxW-1:0]    msb_pos;

   assign launch = (cmd_ff == i2cbe_pkg::CMD_NONE)
                && (action != 3'(i2cbe_pkg::CMD_NONE))
                && (action <= 3'(i2cbe_pkg::CMD_RECV_ACK));

   // next state
   always_comb begin
      cmd_cur   = launch ? i2cbe_pkg::cmd_type'(action) : cmd_ff;
      step_cur  = (launch && action == 3'(i2cbe_pkg::CMD_RECV_BYTE)) ? i2cbe_pkg::StepLead :
                  launch ? i2cbe_pkg::StepFirst : step_ff;
      bit_cur   = launch ? '0 : bit_ff;
      hold_cur  = launch ? '0 : hold_ff;
      fin_cur   = launch ? 1'b0 : fin_ff;
      shift_cur = shift_ff;
      if (launch) begin
         case (i2cbe_pkg::cmd_type'(action))
            i2cbe_pkg::CMD_SEND_BYTE: shift_cur = tx_byte;
            i2cbe_pkg::CMD_SEND_ACK:  shift_cur = {7'd0, ack_to_send};
            default:                  shift_cur = '0;
         endcase
      end
      op       = i2cbe_pkg::op_of(cmd_cur, step_cur);

      active   = (cmd_cur != i2cbe_pkg::CMD_NONE);
      run      = active && (hold_cur == '0) && !fin_cur;
      last_bit = (bit_cur == i2cbe_pkg::BitIdxW'(i2cbe_pkg::BitsPerByte - 1));

      step_in  = step_cur;
      bit_in   = bit_cur;
      fin_in   = fin_cur;
      hold_in  = hold_cur;
      if (active && hold_cur != '0) begin
         hold_in = hold_cur - 1'b1;
      end else if (run) begin
         fin_in = i2cbe_pkg::is_last(cmd_cur, step_cur, last_bit);
         if ((cmd_cur == i2cbe_pkg::CMD_SEND_BYTE || cmd_cur == i2cbe_pkg::CMD_RECV_BYTE)
             && step_cur == i2cbe_pkg::StepBit) begin
            step_in = i2cbe_pkg::StepFirst;
            bit_in  = bit_cur + 1'b1;
         end else begin
            step_in = step_cur + 1'b1;
         end
         if (op == i2cbe_pkg::OP_SCL_HIGH || op == i2cbe_pkg::OP_SCL_LOW) begin
            hold_in = hold_ticks;
         end
      end

      finish = active && fin_in && (hold_in == '0);
      cmd_in = finish ? i2cbe_pkg::CMD_NONE : cmd_cur;
   end

   // phase outputs
   always_comb begin
      msb_pos   = ~bit_cur;
      scl_in    = scl_ff;
      sda_in_nx = sda_ff;
      ack_in    = ack_ff;
      shift_in  = shift_cur;
      rx_in     = rx_ff;
      if (run) begin
         case (op)
            i2cbe_pkg::OP_SDA_HIGH:   sda_in_nx = 1'b1;
            i2cbe_pkg::OP_SDA_LOW:    sda_in_nx = 1'b0;
            i2cbe_pkg::OP_SDA_DATA:   sda_in_nx = shift_cur[msb_pos];
            i2cbe_pkg::OP_SDA_ACK:    sda_in_nx = ~shift_cur[0];
            i2cbe_pkg::OP_SCL_HIGH:   scl_in    = 1'b1;
            i2cbe_pkg::OP_SCL_LOW:    scl_in    = 1'b0;
            i2cbe_pkg::OP_SAMPLE_BIT: shift_in[msb_pos] = shift_cur[msb_pos] | sda_in;
            default:                  ack_in    = ~sda_in;
         endcase
      end
      if (finish && cmd_cur == i2cbe_pkg::CMD_RECV_BYTE) begin
         rx_in = shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff   <= i2cbe_pkg::CMD_NONE;
         step_ff  <= '0;
         bit_ff   <= '0;
         hold_ff  <= '0;
         shift_ff <= '0;
         fin_ff   <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         ack_ff   <= 1'b0;
         rx_ff    <= '0;
      end else if (step_en) begin
         cmd_ff   <= cmd_in;
         step_ff  <= step_in;
         bit_ff   <= bit_in;
         hold_ff  <= hold_in;
         shift_ff <= shift_in;
         fin_ff   <= fin_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_nx;
         ack_ff   <= ack_in;
         rx_ff    <= rx_in;
      end
   end

   assign res.scl_level = scl_in;
   assign res.sda_drive = sda_in_nx;
   assign res.busy_res  = (cmd_in != i2cbe_pkg::CMD_NONE);
   assign res.done_res  = finish;
   assign res.rx_byte   = rx_in;
   assign res.ack_seen  = ack_in;

endmodule

// ===== rtl/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: channels, hold register and response register.
//
// Usage:
//  - req carries one timing tick per transaction: an action code (start, stop,
//    send byte, receive byte, send ack, receive ack), the byte and ack level
//    to send, and the sampled SDA level. Actions arriving while busy are dropped.
//  - rsp returns exactly one transaction per request: SCL level, SDA drive,
//    busy, a one-tick done pulse, the last received byte and the ack seen.
//  - csr_we/csr_wdata write the number of extra ticks held after each SCL edge.
//    Write it only while no command is running.
//  - A response is ready in the cycle after its request is taken; one request
//    is taken every cycle, limited only by the single response register.
//  - When the receiver stalls, the response register holds and req.ready drops
//    until the held response is taken.
//  - Reset releases both lines, clears the sequencer and sets the hold to 5.
`timescale 1ns / 1ps
module i2c_master_bit_engine (
   input  logic                       clock,
   input  logic                       reset,
   i2cbe_req_if.sink                  req,
   i2cbe_rsp_if.source                rsp,
   input  logic                       csr_we,
   input  logic [i2cbe_pkg::HoldW-1:0] csr_wdata
);

   logic [i2cbe_pkg::HoldW-1:0] hold_ticks_ff;
   logic                        rsp_valid_ff;
   i2cbe_pkg::res_type          res_ff;
   i2cbe_pkg::res_type          res_in;
   logic                        accept;

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   i2cbe_core u_core (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .hold_ticks  (hold_ticks_ff),
      .action      (req.action),
      .tx_byte     (req.tx_byte),
      .ack_to_send (req.ack_to_send),
      .sda_in      (req.sda_in),
      .res         (res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= i2cbe_pkg::HoldReset;
      end else if (csr_we) begin
         hold_ticks_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.scl_level = res_ff.scl_level;
   assign rsp.sda_drive = res_ff.sda_drive;
   assign rsp.busy_res  = res_ff.busy_res;
   assign rsp.done_res  = res_ff.done_res;
   assign rsp.rx_byte   = res_ff.rx_byte;
   assign rsp.ack_seen  = res_ff.ack_seen;

endmodule

// ===== rtl/i2cbe_checker.sv =====
// Port-level assertions for the I2C master bit engine and their bind.
`timescale 1ns / 1ps
module i2cbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_busy,
   input logic       rsp_done,
   input logic [7:0] rsp_rx_byte
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_byte) && $stable(rsp_done))
      else $error("response changed while stalled");

   a_req_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted transaction produced no response");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response register full");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_done && rsp_busy))
      else $error("done reported while still busy");

endmodule

bind i2c_master_bit_engine i2cbe_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_busy    (rsp.busy_res),
   .rsp_done    (rsp.done_res),
   .rsp_rx_byte (rsp.rx_byte)
);

// ===== verif/i2c_master_bit_engine_tb.sv =====
// Testbench for the I2C master bit engine: directed and random command traffic with a tick predictor.
`timescale 1ns / 1ps
module i2c_master_bit_engine_tb;

   localparam logic [2:0] ActUndefined = 3'd7;
   localparam int SdaLow  = 0;
   localparam int SdaHigh = 1;
   localparam int SdaRand = 2;
   localparam int WatchdogLimit = 2000;
   localparam int ItemTarget = 950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [i2cbe_pkg::HoldW-1:0] csr_wdata = '0;

   i2cbe_req_if req_if ();
   i2cbe_rsp_if rsp_if ();

   i2c_master_bit_engine u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // engine state as the block should hold it
   logic [i2cbe_pkg::HoldW-1:0] hold_cfg = i2cbe_pkg::HoldReset;
   i2cbe_pkg::cmd_type          eng_cmd = i2cbe_pkg::CMD_NONE;
   logic [4:0]                  eng_phase = '0;
   logic [7:0]                  eng_hold = '0;
   logic [7:0]                  eng_shift = '0;
   logic                        eng_scl = 1'b1;
   logic                        eng_sda = 1'b1;
   logic                        eng_ack = 1'b0;
   logic [7:0]                  eng_rx = '0;

   i2cbe_pkg::res_type tick_results_q[$];
   int      mismatch_count = 0;
   int      items_sent = 0;
   bit      allow_gaps = 1'b1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic i2cbe_pkg::res_type engine_tick(input logic [2:0] act,
                                                      input logic [7:0] tx,
                                                      input logic ack_lvl, input logic sda);
      i2cbe_pkg::res_type r;
      logic               done;
      int                 len;
      int                 k;
      i2cbe_pkg::op_type  op;
      done = 1'b0;
      if (eng_cmd == i2cbe_pkg::CMD_NONE && act >= i2cbe_pkg::CMD_START
          && act <= i2cbe_pkg::CMD_RECV_ACK) begin
         eng_cmd   = i2cbe_pkg::cmd_type'(act);
         eng_phase = '0;
         eng_hold  = '0;
         if (act == i2cbe_pkg::CMD_SEND_BYTE)
            eng_shift = tx;
         else if (act == i2cbe_pkg::CMD_SEND_ACK)
            eng_shift = {7'b0, ack_lvl};
         else
            eng_shift = 8'h00;
      end
      if (eng_cmd != i2cbe_pkg::CMD_NONE) begin
         case (eng_cmd)
            i2cbe_pkg::CMD_START:     len = 4;
            i2cbe_pkg::CMD_STOP:      len = 3;
            i2cbe_pkg::CMD_SEND_BYTE: len = 3 * i2cbe_pkg::BitsPerByte;
            i2cbe_pkg::CMD_RECV_BYTE: len = 1 + 3 * i2cbe_pkg::BitsPerByte;
            i2cbe_pkg::CMD_SEND_ACK:  len = 3;
            default:                  len = 4;
         endcase
         if (eng_hold > 0) begin
            eng_hold = eng_hold - 8'd1;
         end else if (int'(eng_phase) < len) begin
            k = int'(eng_phase);
            case (eng_cmd)
               i2cbe_pkg::CMD_START: begin
                  case (k % 4)
                     0:       op = i2cbe_pkg::OP_SDA_HIGH;
                     1:       op = i2cbe_pkg::OP_SCL_HIGH;
                     2:       op = i2cbe_pkg::OP_SDA_LOW;
                     default: op = i2cbe_pkg::OP_SCL_LOW;
                  endcase
               end
               i2cbe_pkg::CMD_STOP: begin
                  case (k % 3)
                     0:       op = i2cbe_pkg::OP_SDA_LOW;
                     1:       op = i2cbe_pkg::OP_SCL_HIGH;
                     default: op = i2cbe_pkg::OP_SDA_HIGH;
                  endcase
               end
               i2cbe_pkg::CMD_SEND_BYTE: begin
                  case (k % 3)
                     0:       op = i2cbe_pkg::OP_SDA_DATA;
                     1:       op = i2cbe_pkg::OP_SCL_HIGH;
                     default: op = i2cbe_pkg::OP_SCL_LOW;
                  endcase
               end
               i2cbe_pkg::CMD_RECV_BYTE: begin
                  if (k == 0) begin
                     op = i2cbe_pkg::OP_SDA_HIGH;
                  end else begin
                     case ((k - 1) % 3)
                        0:       op = i2cbe_pkg::OP_SCL_HIGH;
                        1:       op = i2cbe_pkg::OP_SAMPLE_BIT;
                        default: op = i2cbe_pkg::OP_SCL_LOW;
                     endcase
                  end
               end
               i2cbe_pkg::CMD_SEND_ACK: begin
                  case (k % 3)
                     0:       op = i2cbe_pkg::OP_SDA_ACK;
                     1:       op = i2cbe_pkg::OP_SCL_HIGH;
                     default: op = i2cbe_pkg::OP_SCL_LOW;
                  endcase
               end
               default: begin
                  case (k % 4)
                     0:       op = i2cbe_pkg::OP_SDA_HIGH;
                     1:       op = i2cbe_pkg::OP_SCL_HIGH;
                     2:       op = i2cbe_pkg::OP_SAMPLE_ACK;
                     default: op = i2cbe_pkg::OP_SCL_LOW;
                  endcase
               end
            endcase
            case (op)
               i2cbe_pkg::OP_SDA_HIGH:   eng_sda = 1'b1;
               i2cbe_pkg::OP_SDA_LOW:    eng_sda = 1'b0;
               i2cbe_pkg::OP_SDA_DATA:   eng_sda = eng_shift[3'(7 - ((k / 3) % 8))];
               i2cbe_pkg::OP_SDA_ACK:    eng_sda = ~eng_shift[0];
               i2cbe_pkg::OP_SCL_HIGH: begin
                  eng_scl  = 1'b1;
                  eng_hold = hold_cfg;
               end
               i2cbe_pkg::OP_SCL_LOW: begin
                  eng_scl  = 1'b0;
                  eng_hold = hold_cfg;
               end
               i2cbe_pkg::OP_SAMPLE_BIT: begin
                  if (sda)
                     eng_shift[3'(7 - (((k - 1) / 3) % 8))] = 1'b1;
               end
               default:                  eng_ack = ~sda;
            endcase
            eng_phase = eng_phase + 5'd1;
         end
         if (int'(eng_phase) >= len && eng_hold == 0) begin
            if (eng_cmd == i2cbe_pkg::CMD_RECV_BYTE)
               eng_rx = eng_shift;
            eng_cmd   = i2cbe_pkg::CMD_NONE;
            eng_phase = '0;
            done      = 1'b1;
         end
      end
      r.scl_level = eng_scl;
      r.sda_drive = eng_sda;
      r.busy_res  = (eng_cmd != i2cbe_pkg::CMD_NONE);
      r.done_res  = done;
      r.rx_byte   = eng_rx;
      r.ack_seen  = eng_ack;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (!allow_gaps)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 93)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic sda_level(input int sel);
      if (sel == SdaLow)
         return 1'b0;
      if (sel == SdaHigh)
         return 1'b1;
      return logic'($urandom_range(0, 1));
   endfunction

   function automatic void check_field(input string name, input logic [7:0] expv,
                                       input logic [7:0] gotv);
      if (gotv !== expv) begin
         $error("%s: expected %0h, got %0h", name, expv, gotv);
         mismatch_count++;
      end
   endfunction

   task automatic send_tick(input logic [2:0] act, input logic [7:0] tx, input logic ack_lvl,
                            input logic sda);
      int                 gap;
      i2cbe_pkg::res_type exp_r;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.action      <= act;
      req_if.tx_byte     <= tx;
      req_if.ack_to_send <= ack_lvl;
      req_if.sda_in      <= sda;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      exp_r = engine_tick(act, tx, ack_lvl, sda);
      tick_results_q.push_back(exp_r);
      items_sent++;
   endtask

   // issue one action, then tick with ignored noise until the engine is idle again
   task automatic run_command(input logic [2:0] act, input logic [7:0] tx, input logic ack_lvl,
                              input int sda_sel);
      send_tick(act, tx, ack_lvl, sda_level(sda_sel));
      while (eng_cmd != i2cbe_pkg::CMD_NONE)
         send_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), sda_level(sda_sel));
   endtask

   task automatic write_hold(input logic [i2cbe_pkg::HoldW-1:0] value);
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tick_results_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      hold_cfg = value;
   endtask

   task automatic test_default_hold();
      run_command(i2cbe_pkg::CMD_NONE, 8'h00, 1'b0, SdaRand);
      run_command(ActUndefined, 8'hFF, 1'b1, SdaRand);
      run_command(i2cbe_pkg::CMD_START, 8'h00, 1'b0, SdaRand);
      run_command(i2cbe_pkg::CMD_SEND_BYTE, 8'hFF, 1'b0, SdaRand);
      run_command(i2cbe_pkg::CMD_RECV_ACK, 8'h00, 1'b0, SdaLow);
      run_command(i2cbe_pkg::CMD_RECV_ACK, 8'h00, 1'b0, SdaHigh);
      run_command(i2cbe_pkg::CMD_RECV_BYTE, 8'h00, 1'b0, SdaHigh);
      run_command(i2cbe_pkg::CMD_SEND_ACK, 8'h00, 1'b1, SdaRand);
      run_command(i2cbe_pkg::CMD_SEND_ACK, 8'h00, 1'b0, SdaRand);
      run_command(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, SdaRand);
   endtask

   task automatic test_zero_hold();
      write_hold('0);
      run_command(i2cbe_pkg::CMD_START, 8'h00, 1'b0, SdaRand);
      run_command(i2cbe_pkg::CMD_SEND_BYTE, 8'hA5, 1'b0, SdaRand);
      run_command(i2cbe_pkg::CMD_RECV_ACK, 8'h00, 1'b0, SdaRand);
      run_command(i2cbe_pkg::CMD_RECV_BYTE, 8'h00, 1'b0, SdaRand);
      run_command(i2cbe_pkg::CMD_SEND_ACK, 8'h00, 1'b1, SdaRand);
      run_command(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, SdaRand);
   endtask

   task automatic test_max_hold();
      write_hold('1);
      run_command(i2cbe_pkg::CMD_STOP, 8'h00, 1'b0, SdaRand);
   endtask

   task automatic random_transfer();
      int n;
      bit reading;
      run_command(i2cbe_pkg::CMD_START, 8'($urandom), 1'($urandom), SdaRand);
      run_command(i2cbe_pkg::CMD_SEND_BYTE, 8'($urandom), 1'($urandom), SdaRand);
      run_command(i2cbe_pkg::CMD_RECV_ACK, 8'($urandom), 1'($urandom),
                  ($urandom_range(0, 99) < 80) ? SdaLow : SdaRand);
      n = $urandom_range(1, 2);
      reading = 1'($urandom);
      for (int i = 0; i < n; i++) begin
         if (reading) begin
            run_command(i2cbe_pkg::CMD_RECV_BYTE, 8'($urandom), 1'($urandom), SdaRand);
            run_command(i2cbe_pkg::CMD_SEND_ACK, 8'($urandom), (i != n - 1), SdaRand);
         end else begin
            run_command(i2cbe_pkg::CMD_SEND_BYTE, 8'($urandom), 1'($urandom), SdaRand);
            run_command(i2cbe_pkg::CMD_RECV_ACK, 8'($urandom), 1'($urandom), SdaRand);
         end
      end
      if ($urandom_range(0, 99) < 85)
         run_command(i2cbe_pkg::CMD_STOP, 8'($urandom), 1'($urandom), SdaRand);
      repeat ($urandom_range(0, 3))
         run_command(($urandom_range(0, 1) != 0) ? ActUndefined : i2cbe_pkg::CMD_NONE,
                     8'($urandom), 1'($urandom), SdaRand);
   endtask

   task automatic random_noise();
      repeat ($urandom_range(1, 8))
         run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), SdaRand);
   endtask

   task automatic test_random_traffic();
      int phase;
      int target;
      int r;
      logic [i2cbe_pkg::HoldW-1:0] hold;
      phase = 0;
      while (items_sent < ItemTarget) begin
         r = $urandom_range(0, 99);
         if (phase < 2)
            hold = i2cbe_pkg::HoldW'(phase);
         else if (r < 60)
            hold = '0;
         else if (r < 90)
            hold = i2cbe_pkg::HoldW'($urandom_range(1, 2));
         else
            hold = i2cbe_pkg::HoldW'($urandom_range(3, 4));
         write_hold(hold);
         allow_gaps = (phase % 4 != 3);
         target = items_sent + 60;
         while (items_sent < target && items_sent < ItemTarget) begin
            if ($urandom_range(0, 99) < 80)
               random_transfer();
            else
               random_noise();
         end
         phase++;
      end
      allow_gaps = 1'b1;
   endtask

   // result side: random stalls, with calm stretches
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_if.ready <= 1'b1;
            if (!reset && $urandom_range(0, 99) < 15)
               stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      i2cbe_pkg::res_type exp_r;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (tick_results_q.size() == 0) begin
            $error("response transaction with no expectation pending");
            mismatch_count++;
         end else begin
            exp_r = tick_results_q.pop_front();
            check_field("scl_level", 8'(exp_r.scl_level), 8'(rsp_if.scl_level));
            check_field("sda_drive", 8'(exp_r.sda_drive), 8'(rsp_if.sda_drive));
            check_field("busy_res", 8'(exp_r.busy_res), 8'(rsp_if.busy_res));
            check_field("done_res", 8'(exp_r.done_res), 8'(rsp_if.done_res));
            check_field("rx_byte", exp_r.rx_byte, rsp_if.rx_byte);
            check_field("ack_seen", 8'(exp_r.ack_seen), 8'(rsp_if.ack_seen));
         end
      end
   end

   initial begin
      int idle;
      idle = 0;
      wait (!reset);
      while (idle < WatchdogLimit) begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle = 0;
         else
            idle++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      req_if.valid       = 1'b0;
      req_if.action      = i2cbe_pkg::CMD_NONE;
      req_if.tx_byte     = '0;
      req_if.ack_to_send = 1'b0;
      req_if.sda_in      = 1'b1;
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_default_hold();
      test_zero_hold();
      test_max_hold();
      test_random_traffic();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tick_results_q.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);
      if (mismatch_count == 0 && tick_results_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
